FILE: rtl/tpt_pkg.sv
// Package for the three channel prescaled down timer: widths, codes, types and the select decoder.
package tpt_pkg;

  localparam int NUM_CH    = 3;
  localparam int CYC_W     = 12;
  localparam int ACC_W     = CYC_W + 1;
  localparam int BIDX_W    = $clog2(ACC_W);
  localparam int CH_W      = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int DATA_W    = 32;
  localparam int CTRL_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int SEL_W     = 4;
  localparam int CMD_W     = 2;
  localparam int IRQ_W     = 3;
  localparam int SHIFT_W   = 4;
  localparam int MODE_W    = 3;

  localparam int S_TDATA_W = ((DATA_W + CYC_W + 7) / 8) * 8;
  localparam int S_TUSER_W = CMD_W + SEL_W;
  localparam int M_TDATA_W = ((DATA_W + IRQ_W + 7) / 8) * 8;

  localparam int FLAG_BIT  = 8;   // underflow flag in control word
  localparam int IE_BIT    = 5;   // underflow interrupt enable

  localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(4);
  localparam logic [MODE_W-1:0]  MODE_MAX  = MODE_W'(4);
  localparam logic [SEL_W-1:0]   SEL_TOCR  = SEL_W'(0);
  localparam logic [SEL_W-1:0]   SEL_TSTR  = SEL_W'(1);
  localparam logic [ACC_W-1:0]   ACC_ONES  = {ACC_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_TOCR,
    KIND_TSTR,
    KIND_CONST,
    KIND_COUNT,
    KIND_CTRL,
    KIND_NONE
  } reg_kind_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_ACCESS,
    OP_TICK,
    OP_EVAL,
    OP_DIV,
    OP_FIN,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_TICK,
    ST_EVAL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    reg_kind_e       kind;
    logic [CH_W-1:0] ch;
  } sel_dec_t;

  typedef struct packed {
    op_e               op;
    logic [CH_W-1:0]   ch;
    logic [BIDX_W-1:0] bidx;
  } dp_cmd_t;

  typedef struct packed {
    logic in_tick;   // item at the slave port is a tick
    logic started;   // current channel is running
    logic uflow;     // steps exceed counter
    logic need_div;  // leftover steps exceed reload value
  } dp_stat_t;

  // Register map: 0 TOCR, 1 TSTR, then constant, count, control per channel.
  function automatic sel_dec_t decode_sel(input logic [SEL_W-1:0] sel);
    sel_dec_t d;
    d.kind = KIND_NONE;
    d.ch   = '0;
    if (sel == SEL_TOCR) begin
      d.kind = KIND_TOCR;
    end else if (sel == SEL_TSTR) begin
      d.kind = KIND_TSTR;
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        for (int k = 0; k < 3; k++) begin
          if ((2 + 3 * c + k) < (1 << SEL_W) && sel == SEL_W'(2 + 3 * c + k)) begin
            d.ch = CH_W'(c);
            if (k == 0) begin
              d.kind = KIND_CONST;
            end else if (k == 1) begin
              d.kind = KIND_COUNT;
            end else begin
              d.kind = KIND_CTRL;
            end
          end
        end
      end
    end
    return d;
  endfunction

endpackage

FILE: rtl/tpt_ctrl.sv
// Sequencer of the timer: item intake, channel walk, remainder iterations and result hand-off.
module tpt_ctrl
  import tpt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e            state_q, state_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [BIDX_W-1:0] bidx_q, bidx_d;
  logic              out_valid_q, out_valid_d;
  logic              last_ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      bidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      bidx_q      <= bidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    bidx_d      = bidx_q;
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_IDLE;
    cmd_o.ch    = ch_q;
    cmd_o.bidx  = bidx_q;
    last_ch     = (ch_q == CH_W'(NUM_CH - 1));

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          ch_d     = '0;
          state_d  = stat_i.in_tick ? ST_TICK : ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd_o.op = OP_ACCESS;
        state_d  = ST_DONE;
      end
      ST_TICK: begin
        cmd_o.op = OP_TICK;
        if (stat_i.started) begin
          state_d = ST_EVAL;
        end else if (last_ch) begin
          state_d = ST_DONE;
        end else begin
          ch_d    = ch_q + CH_W'(1);
          state_d = ST_TICK;
        end
      end
      ST_EVAL: begin
        cmd_o.op = OP_EVAL;
        if (stat_i.uflow && stat_i.need_div) begin
          bidx_d  = BIDX_W'(ACC_W - 1);
          state_d = ST_DIV;
        end else if (stat_i.uflow) begin
          state_d = ST_FIN;
        end else if (last_ch) begin
          state_d = ST_DONE;
        end else begin
          ch_d    = ch_q + CH_W'(1);
          state_d = ST_TICK;
        end
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (bidx_q == '0) begin
          state_d = ST_FIN;
        end else begin
          bidx_d = bidx_q - BIDX_W'(1);
        end
      end
      ST_FIN: begin
        cmd_o.op = OP_FIN;
        if (last_ch) begin
          state_d = ST_DONE;
        end else begin
          ch_d    = ch_q + CH_W'(1);
          state_d = ST_TICK;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.op == OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/tpt_dp.sv
// Datapath of the timer: channel registers, prescaler, counter update, remainder unit, result register.
module tpt_dp
  import tpt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CMD_W-1:0]     in_cmd_i,
  input  logic [SEL_W-1:0]     in_sel_i,
  input  logic [DATA_W-1:0]    in_wdata_i,
  input  logic [CYC_W-1:0]     in_cycles_i,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  output logic [DATA_W-1:0]    out_rdata_o,
  output logic [IRQ_W-1:0]     out_irq_o
);

  // Timer state
  logic [DATA_W-1:0]  count_q  [NUM_CH];
  logic [DATA_W-1:0]  reload_q [NUM_CH];
  logic [CTRL_W-1:0]  ctrl_q   [NUM_CH];
  logic [ACC_W-1:0]   acc_q    [NUM_CH];
  logic [SHIFT_W-1:0] shift_q  [NUM_CH];
  logic [MODE_W-1:0]  mode_q   [NUM_CH];
  logic [BYTE_W-1:0]  tstr_q;
  logic [BYTE_W-1:0]  tocr_q;

  // Item and work registers
  cmd_e               item_cmd_q;
  sel_dec_t           item_sel_q;
  logic [DATA_W-1:0]  wdata_q;
  logic [CYC_W-1:0]   cycles_q;
  logic [DATA_W-1:0]  rd_q;
  logic [ACC_W-1:0]   steps_q;
  logic [ACC_W-1:0]   rem_q;
  logic               use_rem_q;
  logic [DATA_W-1:0]  out_rdata_q;
  logic [IRQ_W-1:0]   out_irq_q;

  logic [CH_W-1:0]    idx;
  logic [ACC_W-1:0]   acc_new;
  logic [ACC_W-1:0]   acc_steps;
  logic [ACC_W-1:0]   acc_keep;
  logic [ACC_W-1:0]   diff;
  logic [ACC_W-1:0]   dvd;
  logic [ACC_W:0]     rem_sh;
  logic               rem_ge;
  logic [ACC_W-1:0]   rem_next;
  logic [ACC_W-1:0]   fin_steps;
  logic [MODE_W-1:0]  wr_mode;
  logic [IRQ_W-1:0]   irq;
  logic               is_wr;
  logic               is_rd;

  assign idx = (cmd_i.op == OP_ACCESS) ? item_sel_q.ch : cmd_i.ch;

  always_comb begin
    acc_new   = acc_q[idx] + ACC_W'(cycles_q);
    acc_steps = acc_new >> shift_q[idx];
    acc_keep  = acc_new & ~(ACC_ONES << shift_q[idx]);
    diff      = steps_q - count_q[idx][ACC_W-1:0];
    dvd       = steps_q - ACC_W'(1);
    rem_sh    = {rem_q, dvd[cmd_i.bidx]};
    rem_ge    = {{(DATA_W - ACC_W - 1){1'b0}}, rem_sh} >= reload_q[idx];
    rem_next  = rem_ge ? ACC_W'(rem_sh - reload_q[idx][ACC_W:0]) : rem_sh[ACC_W-1:0];
    fin_steps = use_rem_q ? (rem_q + ACC_W'(1)) : steps_q;
    wr_mode   = wdata_q[MODE_W-1:0];
    is_wr     = (item_cmd_q == CMD_WRITE);
    is_rd     = (item_cmd_q == CMD_READ);
    for (int c = 0; c < IRQ_W; c++) begin
      irq[c] = (c < NUM_CH) ? (ctrl_q[c][FLAG_BIT] & ctrl_q[c][IE_BIT]) : 1'b0;
    end
  end

  assign stat_o.in_tick  = (cmd_e'(in_cmd_i) == CMD_TICK);
  assign stat_o.started  = tstr_q[cmd_i.ch];
  assign stat_o.uflow    = {{(DATA_W - ACC_W){1'b0}}, steps_q} > count_q[idx];
  assign stat_o.need_div = (reload_q[idx] != '0) &&
                           ({{(DATA_W - ACC_W){1'b0}}, diff} > reload_q[idx]);

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++) begin
        count_q[c]  <= '1;
        reload_q[c] <= '1;
        ctrl_q[c]   <= '0;
        acc_q[c]    <= '0;
        shift_q[c]  <= SHIFT_RST;
        mode_q[c]   <= '0;
      end
      tstr_q <= '0;
      tocr_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_ACCESS: begin
          if (is_wr) begin
            unique case (item_sel_q.kind)
              KIND_TOCR:  tocr_q        <= wdata_q[BYTE_W-1:0];
              KIND_TSTR:  tstr_q        <= wdata_q[BYTE_W-1:0];
              KIND_CONST: reload_q[idx] <= wdata_q;
              KIND_COUNT: count_q[idx]  <= wdata_q;
              KIND_CTRL: begin
                ctrl_q[idx] <= wdata_q[CTRL_W-1:0];
                if (wr_mode != mode_q[idx]) begin
                  mode_q[idx] <= wr_mode;
                  acc_q[idx]  <= '0;
                  if (wr_mode <= MODE_MAX) begin
                    shift_q[idx] <= SHIFT_W'({wr_mode, 1'b0}) + SHIFT_RST;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        OP_TICK: begin
          if (tstr_q[idx]) begin
            acc_q[idx] <= acc_keep;
          end
        end
        OP_EVAL: begin
          if (stat_o.uflow) begin
            count_q[idx]          <= reload_q[idx];
            ctrl_q[idx][FLAG_BIT] <= 1'b1;
          end else begin
            count_q[idx] <= count_q[idx] - DATA_W'(steps_q);
          end
        end
        OP_FIN: begin
          count_q[idx] <= count_q[idx] - DATA_W'(fin_steps);
        end
        default: ;
      endcase
    end
  end

  // Item, work and result registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        item_cmd_q <= cmd_e'(in_cmd_i);
        item_sel_q <= decode_sel(in_sel_i);
        wdata_q    <= in_wdata_i;
        cycles_q   <= in_cycles_i;
        rd_q       <= '0;
      end
      OP_ACCESS: begin
        if (is_rd) begin
          unique case (item_sel_q.kind)
            KIND_TOCR:  rd_q <= DATA_W'(tocr_q);
            KIND_TSTR:  rd_q <= DATA_W'(tstr_q);
            KIND_CONST: rd_q <= reload_q[idx];
            KIND_COUNT: rd_q <= count_q[idx];
            KIND_CTRL:  rd_q <= DATA_W'(ctrl_q[idx]);
            default:    rd_q <= '0;
          endcase
        end
      end
      OP_TICK: begin
        steps_q <= acc_steps;
      end
      OP_EVAL: begin
        use_rem_q <= 1'b0;
        rem_q     <= '0;
        if (stat_o.uflow) begin
          steps_q <= diff;
        end
      end
      OP_DIV: begin
        use_rem_q <= 1'b1;
        rem_q     <= rem_next;
      end
      OP_OUT: begin
        out_rdata_q <= rd_q;
        out_irq_q   <= irq;
      end
      default: ;
    endcase
  end

  assign out_rdata_o = out_rdata_q;
  assign out_irq_o   = out_irq_q;

endmodule

FILE: rtl/three_channel_prescaled_down_timer.sv
// Top level of the three channel prescaled down timer: stream ports around sequencer and datapath.
//
// Usage notes
// - Slave stream carries one item per transfer: tuser holds the command (tick, register
//   write, register read, no-op) and the register select; tdata holds write data and the
//   core cycle count of a tick.
// - Master stream returns exactly one result per item: the read data (zero unless a read
//   of a mapped register) and the three interrupt lines (underflow flag AND enable).
// - Items are worked one at a time by the sequencer. A register access passes its access
//   step and then loads its result; the next item is taken once the sequencer is idle again.
//   A tick walks the channels in turn: a stopped channel is passed over, a running one is
//   evaluated, an underflow adds a finishing step, and leftover steps above the reload value
//   first go through the 13-step remainder unit; then the result is loaded before the next item.
// - The result sits in an output register; the next item is accepted while it still
//   waits, and the sequencer only holds in its last step when a second result is ready
//   and the receiver stalls.
// - Reset (rst_ni low, asynchronous) sets counters and constants to all ones, control
//   words, prescalers, start and output control bits to zero, and every divider to 16.
module three_channel_prescaled_down_timer
  import tpt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Slave stream: items
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // [31:0] wdata, [43:32] cycles, rest zero
  input  logic [S_TUSER_W-1:0] s_axis_tuser_i,   // [1:0] cmd, [5:2] reg_sel
  // Master stream: results
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o    // [31:0] rdata, [34:32] irq_lines, rest zero
);

  dp_cmd_t           dp_cmd;
  dp_stat_t          dp_stat;
  logic [DATA_W-1:0] rdata;
  logic [IRQ_W-1:0]  irq_lines;

  tpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  tpt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_cmd_i    (s_axis_tuser_i[CMD_W-1:0]),
    .in_sel_i    (s_axis_tuser_i[CMD_W+SEL_W-1:CMD_W]),
    .in_wdata_i  (s_axis_tdata_i[DATA_W-1:0]),
    .in_cycles_i (s_axis_tdata_i[DATA_W+CYC_W-1:DATA_W]),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_rdata_o (rdata),
    .out_irq_o   (irq_lines)
  );

  // Pack result fields, zero pad to whole bytes
  assign m_axis_tdata_o = {{(M_TDATA_W - DATA_W - IRQ_W){1'b0}}, irq_lines, rdata};

endmodule
